FILE: hdl/gated_nearest_landmark_match_macros.svh
// Assertion macros for the landmark matcher.
// Define NO_ASSERTIONS to compile every check away.
`ifndef GATED_NEAREST_LANDMARK_MATCH_MACROS_SVH
`define GATED_NEAREST_LANDMARK_MATCH_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check the effect in the same cycle as the cause
`define GLNM_ASSERT_SAME(label, clk, rst, cause, effect, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |-> (effect)) \
      else $error(msg);

// Check the effect in the cycle after the cause
`define GLNM_ASSERT_NEXT(label, clk, rst, cause, effect, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
      else $error(msg);

`else

`define GLNM_ASSERT_SAME(label, clk, rst, cause, effect, msg)
`define GLNM_ASSERT_NEXT(label, clk, rst, cause, effect, msg)

`endif

`endif

FILE: hdl/glnm_pkg.sv
package glnm_pkg;

   // Default table depth
   localparam int MAX_OBSTACLES_DEFAULT = 64;

   // Register and field widths
   localparam int SEP_W   = 15;
   localparam int COORD_W = 16;
   localparam int INDEX_W = 6;

   localparam logic [SEP_W-1:0] MAX_SEP_RESET = 15'd512;

   // Item kinds
   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_APPEND = 2'd1;
   localparam logic [1:0] KIND_MATCH  = 2'd2;

   // Cycles from the last table entry entering the distance unit to a settled best
   localparam int DRAIN_CYCLES = 2;

   typedef struct packed {
      logic [1:0]                 kind;
      logic signed [COORD_W-1:0]  pos_x;
      logic signed [COORD_W-1:0]  pos_y;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]  corrected_x;
      logic signed [COORD_W-1:0]  corrected_y;
      logic                       matched;
      logic [INDEX_W-1:0]         match_index;
   } rsp_payload_type;

   // One stored obstacle position
   typedef struct packed {
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
   } entry_type;

   // Control from the sequencer to the distance unit
   typedef struct packed {
      logic start;
      logic valid;
   } dist_ctl_type;

endpackage

FILE: hdl/glnm_stream_if.sv
interface glnm_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/gated_nearest_landmark_match.sv
// Channel  Direction  Transfer carries
// req      in         kind, pos_x, pos_y
// rsp      out        corrected_x, corrected_y, matched, match_index (match only)
// csr      in         max_separation, written when csr_write_enable is high
//
// Clear and append do not leave idle; req_ready stays high for them.
// A match turns the obstacle ring once through its MAX_OBSTACLES cells,
// feeding one entry a cycle to the distance unit, then its pipeline drains
// and the result is loaded.
// Reset clears the entry count and sets max_separation to 512; no table sweep.
// The result register holds one result; clears and appends flow while it waits,
// but a stalled rsp holds a finished match and blocks all requests.
`include "gated_nearest_landmark_match_macros.svh"

module gated_nearest_landmark_match #(
   parameter int MAX_OBSTACLES = glnm_pkg::MAX_OBSTACLES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [glnm_pkg::SEP_W-1:0]  csr_write_data,
   glnm_stream_if.sink                 req,
   glnm_stream_if.source               rsp
);

   localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);
   localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type                   state_ff, state_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            step_ff, step_in;
   logic [glnm_pkg::SEP_W-1:0]  sep_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   glnm_pkg::rsp_payload_type   rsp_data_ff, rsp_data_in;

   glnm_pkg::entry_type         cell_q [MAX_OBSTACLES];
   glnm_pkg::entry_type         head_d;
   glnm_pkg::entry_type         new_entry;
   logic                        shift_en;
   logic                        req_accept;
   logic                        is_match;
   logic                        is_append;
   logic                        is_clear;
   logic                        not_full;
   logic                        rsp_load;
   logic [CNT_W:0]              pos_sum;
   logic [CNT_W:0]              slot_wide;
   logic                        in_range;
   glnm_pkg::dist_ctl_type      dist_ctl;
   logic                        found;
   glnm_pkg::entry_type         best;
   logic [IDX_W-1:0]            best_slot;

   // Decode the request
   assign req.ready  = (state_ff == ST_IDLE);
   assign req_accept = req.valid && req.ready;
   assign is_clear   = (req.payload.kind == glnm_pkg::KIND_CLEAR);
   assign is_append  = (req.payload.kind == glnm_pkg::KIND_APPEND);
   assign is_match   = (req.payload.kind == glnm_pkg::KIND_MATCH);
   assign not_full   = (count_ff < CNT_W'(MAX_OBSTACLES));
   assign new_entry  = '{x: req.payload.pos_x, y: req.payload.pos_y};

   // Rotate the ring during a scan, push at the head on an append
   assign shift_en = (state_ff == ST_SCAN) || (req_accept && is_append && not_full);
   assign head_d   = (state_ff == ST_SCAN) ? cell_q[MAX_OBSTACLES-1] : new_entry;

   for (genvar i = 0; i < MAX_OBSTACLES; i++) begin : g_cell
      if (i == 0) begin : g_head
         glnm_cell u_cell (
            .clock (clock),
            .shift (shift_en),
            .d     (head_d),
            .q     (cell_q[i])
         );
      end else begin : g_body
         glnm_cell u_cell (
            .clock (clock),
            .shift (shift_en),
            .d     (cell_q[i-1]),
            .q     (cell_q[i])
         );
      end
   end

   // The tail shows slot 0 first once step reaches MAX_OBSTACLES - count
   assign pos_sum   = {1'b0, step_ff} + {1'b0, count_ff};
   assign in_range  = (pos_sum >= (CNT_W+1)'(MAX_OBSTACLES));
   assign slot_wide = pos_sum - (CNT_W+1)'(MAX_OBSTACLES);

   assign dist_ctl.start = req_accept && is_match;
   assign dist_ctl.valid = (state_ff == ST_SCAN) && in_range;

   glnm_dist #(
      .MAX_OBSTACLES (MAX_OBSTACLES)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .ctl       (dist_ctl),
      .max_sep   (sep_ff),
      .landmark  (new_entry),
      .cand      (cell_q[MAX_OBSTACLES-1]),
      .cand_slot (slot_wide[IDX_W-1:0]),
      .found     (found),
      .best      (best),
      .best_slot (best_slot)
   );

   // Sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      step_in  = step_ff;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (is_clear) begin
                  count_in = '0;
               end else if (is_append && not_full) begin
                  count_in = count_ff + 1'b1;
               end else if (is_match) begin
                  state_in = ST_SCAN;
                  step_in  = '0;
               end
            end
         end
         ST_SCAN: begin
            if (step_ff == CNT_W'(MAX_OBSTACLES - 1)) begin
               state_in = ST_DRAIN;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (step_ff == CNT_W'(glnm_pkg::DRAIN_CYCLES - 1)) begin
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.corrected_x  = best.x;
         rsp_data_in.corrected_y  = best.y;
         rsp_data_in.matched      = found;
         rsp_data_in.match_index  = glnm_pkg::INDEX_W'(best_slot);
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         sep_ff       <= glnm_pkg::MAX_SEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            sep_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   // Checks
   `GLNM_ASSERT_NEXT(a_clear_empties, clock, reset, req_accept && is_clear, count_ff == '0, "clear did not empty the table")
   `GLNM_ASSERT_NEXT(a_full_holds, clock, reset, req_accept && is_append && !not_full, count_ff == CNT_W'(MAX_OBSTACLES), "append to a full table changed the count")
   `GLNM_ASSERT_NEXT(a_match_starts, clock, reset, req_accept && is_match, (state_ff == ST_SCAN) && (step_ff == '0), "match did not start a scan")
   `GLNM_ASSERT_NEXT(a_scan_ends, clock, reset, (state_ff == ST_SCAN) && (step_ff == CNT_W'(MAX_OBSTACLES - 1)), state_ff == ST_DRAIN, "scan did not end after one turn")

endmodule

FILE: hdl/glnm_cell.sv
module glnm_cell (
   input  logic                clock,
   input  logic                shift,
   input  glnm_pkg::entry_type d,
   output glnm_pkg::entry_type q
);

   glnm_pkg::entry_type entry_ff;

   // Take the neighbor's entry on a shift, hold otherwise
   always_ff @(posedge clock) begin
      if (shift) begin
         entry_ff <= d;
      end
   end

   assign q = entry_ff;

endmodule

FILE: hdl/glnm_dist.sv
module glnm_dist #(
   parameter int MAX_OBSTACLES = glnm_pkg::MAX_OBSTACLES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  glnm_pkg::dist_ctl_type      ctl,
   input  logic [glnm_pkg::SEP_W-1:0]  max_sep,
   input  glnm_pkg::entry_type         landmark,
   input  glnm_pkg::entry_type         cand,
   input  logic [((MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1)-1:0] cand_slot,
   output logic                        found,
   output glnm_pkg::entry_type         best,
   output logic [((MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1)-1:0] best_slot
);

   localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
   localparam int CW    = glnm_pkg::COORD_W;
   localparam int SQ_W  = 2 * CW;
   localparam int D2_W  = SQ_W + 1;
   localparam int LIM_W = 2 * glnm_pkg::SEP_W;

   glnm_pkg::entry_type land_ff;

   // Stage A: absolute differences
   logic                a_valid_ff, a_valid_in;
   logic [CW-1:0]       a_abs_x_ff, a_abs_x_in;
   logic [CW-1:0]       a_abs_y_ff, a_abs_y_in;
   glnm_pkg::entry_type a_entry_ff;
   logic [IDX_W-1:0]    a_slot_ff;

   // Stage B: squares
   logic                b_valid_ff, b_valid_in;
   logic [SQ_W-1:0]     b_sq_x_ff, b_sq_x_in;
   logic [SQ_W-1:0]     b_sq_y_ff, b_sq_y_in;
   glnm_pkg::entry_type b_entry_ff;
   logic [IDX_W-1:0]    b_slot_ff;

   // Best so far
   logic                found_ff, found_in;
   logic [D2_W-1:0]     best_d2_ff, best_d2_in;
   glnm_pkg::entry_type best_ff, best_in;
   logic [IDX_W-1:0]    best_slot_ff, best_slot_in;

   logic signed [CW:0]  dx;
   logic signed [CW:0]  dy;
   logic [CW:0]         mag_x;
   logic [CW:0]         mag_y;
   logic [LIM_W-1:0]    limit;
   logic [D2_W-1:0]     d2;

   // Difference to the landmark, then magnitude
   always_comb begin
      dx         = {land_ff.x[CW-1], land_ff.x} - {cand.x[CW-1], cand.x};
      dy         = {land_ff.y[CW-1], land_ff.y} - {cand.y[CW-1], cand.y};
      mag_x      = dx[CW] ? (~dx + 1'b1) : dx;
      mag_y      = dy[CW] ? (~dy + 1'b1) : dy;
      a_abs_x_in = mag_x[CW-1:0];
      a_abs_y_in = mag_y[CW-1:0];
      a_valid_in = ctl.valid;
   end

   // Square each magnitude
   always_comb begin
      b_sq_x_in  = {{CW{1'b0}}, a_abs_x_ff} * {{CW{1'b0}}, a_abs_x_ff};
      b_sq_y_in  = {{CW{1'b0}}, a_abs_y_ff} * {{CW{1'b0}}, a_abs_y_ff};
      b_valid_in = a_valid_ff;
   end

   // Keep the strictly smaller distance, earlier slot wins ties
   always_comb begin
      limit        = {{glnm_pkg::SEP_W{1'b0}}, max_sep} * {{glnm_pkg::SEP_W{1'b0}}, max_sep};
      d2           = {1'b0, b_sq_x_ff} + {1'b0, b_sq_y_ff};
      found_in     = found_ff;
      best_d2_in   = best_d2_ff;
      best_in      = best_ff;
      best_slot_in = best_slot_ff;
      if (ctl.start) begin
         found_in     = 1'b0;
         best_d2_in   = {{(D2_W-LIM_W){1'b0}}, limit};
         best_in      = landmark;
         best_slot_in = '0;
      end else if (b_valid_ff && (d2 < best_d2_ff)) begin
         found_in     = 1'b1;
         best_d2_in   = d2;
         best_in      = b_entry_ff;
         best_slot_in = b_slot_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         found_ff   <= found_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         land_ff <= landmark;
      end
      a_abs_x_ff   <= a_abs_x_in;
      a_abs_y_ff   <= a_abs_y_in;
      a_entry_ff   <= cand;
      a_slot_ff    <= cand_slot;
      b_sq_x_ff    <= b_sq_x_in;
      b_sq_y_ff    <= b_sq_y_in;
      b_entry_ff   <= a_entry_ff;
      b_slot_ff    <= a_slot_ff;
      best_d2_ff   <= best_d2_in;
      best_ff      <= best_in;
      best_slot_ff <= best_slot_in;
   end

   assign found     = found_ff;
   assign best      = best_ff;
   assign best_slot = best_slot_ff;

endmodule

FILE: tb/tb_gated_nearest_landmark_match.sv
`timescale 1ns / 1ps

module tb_gated_nearest_landmark_match;

   localparam int DEPTH         = glnm_pkg::MAX_OBSTACLES_DEFAULT;
   localparam int COORD_W       = glnm_pkg::COORD_W;
   localparam int SEP_W         = glnm_pkg::SEP_W;
   localparam int INDEX_W       = glnm_pkg::INDEX_W;
   localparam int SETTLE_CYCLES = DEPTH + 16;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int REPORT_MAX    = 10;

   // Kind code that the block has to ignore
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [SEP_W-1:0]    csr_write_data = '0;

   glnm_stream_if #(.payload_type(glnm_pkg::req_payload_type)) req_if ();
   glnm_stream_if #(.payload_type(glnm_pkg::rsp_payload_type)) rsp_if ();

   gated_nearest_landmark_match dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_if),
      .rsp              (rsp_if)
   );

   // Shadow of the obstacle table and the separation register
   logic signed [COORD_W-1:0] obst_x [DEPTH];
   logic signed [COORD_W-1:0] obst_y [DEPTH];
   int                        obst_count = 0;
   logic [SEP_W-1:0]          sep_limit = glnm_pkg::MAX_SEP_RESET;

   glnm_pkg::req_payload_type pending [$];
   glnm_pkg::rsp_payload_type lookups_due [$];

   logic req_fired = 1'b0;
   int   idle_pct = 8;
   int   cycle_count = 0;
   int   mismatches = 0;
   int   n_queued = 0;
   int   n_taken = 0;
   int   n_lookups = 0;
   int   n_hits = 0;
   int   n_dropped = 0;
   int   n_settings = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Update the shadow table for one accepted request; queue the lookup answer
   function automatic void apply_request(input glnm_pkg::req_payload_type r);
      longint                    lim, best, d2, dx, dy;
      int                        slot, i;
      bit                        hit;
      glnm_pkg::rsp_payload_type ans;
      case (r.kind)
         glnm_pkg::KIND_CLEAR: obst_count = 0;
         glnm_pkg::KIND_APPEND: begin
            if (obst_count < DEPTH) begin
               obst_x[obst_count] = r.pos_x;
               obst_y[obst_count] = r.pos_y;
               obst_count++;
            end else begin
               n_dropped++;
            end
         end
         glnm_pkg::KIND_MATCH: begin
            lim  = longint'(sep_limit) * longint'(sep_limit);
            best = lim;
            hit  = 1'b0;
            slot = 0;
            // Strict compare keeps the earliest slot on a tie
            for (i = 0; i < obst_count; i++) begin
               dx = longint'($signed(r.pos_x)) - longint'($signed(obst_x[i]));
               dy = longint'($signed(r.pos_y)) - longint'($signed(obst_y[i]));
               d2 = dx * dx + dy * dy;
               if (d2 < best) begin
                  best = d2;
                  slot = i;
                  hit  = 1'b1;
               end
            end
            if (hit) begin
               ans.corrected_x = obst_x[slot];
               ans.corrected_y = obst_y[slot];
               ans.matched     = 1'b1;
               ans.match_index = INDEX_W'(slot);
            end else begin
               ans.corrected_x = r.pos_x;
               ans.corrected_y = r.pos_y;
               ans.matched     = 1'b0;
               ans.match_index = '0;
            end
            lookups_due = {lookups_due, ans};
         end
         default: ;
      endcase
   endfunction

   function automatic void note_mismatch(input string what,
                                         input glnm_pkg::rsp_payload_type want,
                                         input glnm_pkg::rsp_payload_type got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("[%0t] %s: expected %0d,%0d hit=%0b slot=%0d, got %0d,%0d hit=%0b slot=%0d",
                  $realtime, what, want.corrected_x, want.corrected_y, want.matched,
                  want.match_index, got.corrected_x, got.corrected_y, got.matched,
                  got.match_index);
   endfunction

   // Driver: present requests and the result ready at the falling edge
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= idle_pct);
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fired) begin
         if (pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_if.payload <= pending.pop_front();
            req_if.valid   <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Monitor: predict on each request transfer, check each result transfer
   always @(posedge clock) begin
      glnm_pkg::rsp_payload_type want;
      req_fired <= !reset && req_if.valid && req_if.ready;
      if (!reset && req_if.valid && req_if.ready) begin
         apply_request(req_if.payload);
         n_taken++;
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (lookups_due.size() == 0) begin
            want = '0;
            note_mismatch("result with no lookup pending", want, rsp_if.payload);
         end else begin
            want = lookups_due.pop_front();
            n_lookups++;
            if (want.matched)
               n_hits++;
            if (rsp_if.payload.corrected_x !== want.corrected_x ||
                rsp_if.payload.corrected_y !== want.corrected_y ||
                rsp_if.payload.matched     !== want.matched ||
                rsp_if.payload.match_index !== want.match_index)
               note_mismatch("lookup mismatch", want, rsp_if.payload);
         end
      end
   end

   function automatic int clip16(input int v);
      if (v > 32767)
         return 32767;
      if (v < -32768)
         return -32768;
      return v;
   endfunction

   function automatic int rand_coord();
      logic [COORD_W-1:0] v;
      v = COORD_W'($urandom);
      return int'($signed(v));
   endfunction

   function automatic int rand_offset(input int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   task automatic push_item(input logic [1:0] k, input int x, input int y);
      glnm_pkg::req_payload_type r;
      r.kind  = k;
      r.pos_x = COORD_W'(clip16(x));
      r.pos_y = COORD_W'(clip16(y));
      pending = {pending, r};
      n_queued++;
   endtask

   // Hold the sender until all requests are taken and all lookups answered
   task automatic drain();
      @(negedge clock);
      while (pending.size() != 0 || req_if.valid || lookups_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_max_sep(input logic [SEP_W-1:0] v);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sep_limit = v;
      n_settings++;
   endtask

   // One scene: optional clear, a cluster of obstacles, then lookups with stray appends and ignored kinds
   task automatic run_scene(input int n_obst, input int n_probe);
      int cx, cy, spread, k, j, r, px, py;
      int ox [$];
      int oy [$];
      if ($urandom_range(99) < 80)
         push_item(glnm_pkg::KIND_CLEAR, rand_coord(), rand_coord());
      cx = rand_coord();
      cy = rand_coord();
      spread = int'(sep_limit) * 3 + 8;
      if (spread > 40000)
         spread = 40000;
      for (k = 0; k < n_obst; k++) begin
         r = $urandom_range(99);
         if (ox.size() != 0 && r < 10) begin
            j  = $urandom_range(ox.size() - 1);
            px = ox[j];
            py = oy[j];
         end else if (r < 20) begin
            px = rand_coord();
            py = rand_coord();
         end else begin
            px = clip16(cx + rand_offset(spread));
            py = clip16(cy + rand_offset(spread));
         end
         ox = {ox, px};
         oy = {oy, py};
         push_item(glnm_pkg::KIND_APPEND, px, py);
      end
      for (k = 0; k < n_probe; k++) begin
         r = $urandom_range(99);
         if (r < 8) begin
            push_item(KIND_UNUSED, rand_coord(), rand_coord());
         end else if (r < 12) begin
            push_item(glnm_pkg::KIND_APPEND, cx + rand_offset(spread),
                      cy + rand_offset(spread));
         end else if (ox.size() != 0 && r < 40) begin
            j = $urandom_range(ox.size() - 1);
            push_item(glnm_pkg::KIND_MATCH, ox[j], oy[j]);
         end else if (ox.size() != 0 && r < 85) begin
            j = $urandom_range(ox.size() - 1);
            push_item(glnm_pkg::KIND_MATCH, ox[j] + rand_offset(spread / 2),
                      oy[j] + rand_offset(spread / 2));
         end else if (r < 93) begin
            push_item(glnm_pkg::KIND_MATCH, cx + rand_offset(spread),
                      cy + rand_offset(spread));
         end else begin
            push_item(glnm_pkg::KIND_MATCH, rand_coord(), rand_coord());
         end
      end
   endtask

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("gated_nearest_landmark_match verification failed");
      $finish;
   end

   initial begin
      logic [SEP_W-1:0] sep_plan [8];
      int               p, goal, r;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, ignored kind, limit edge, tie, extremes, clear
      push_item(glnm_pkg::KIND_MATCH, -32768, 32767);
      push_item(KIND_UNUSED, 32767, -32768);
      push_item(glnm_pkg::KIND_MATCH, 0, 0);
      push_item(glnm_pkg::KIND_APPEND, 0, 0);
      push_item(glnm_pkg::KIND_APPEND, 0, 0);
      push_item(glnm_pkg::KIND_MATCH, 511, 0);
      push_item(glnm_pkg::KIND_MATCH, 512, 0);
      push_item(glnm_pkg::KIND_MATCH, 0, -511);
      push_item(glnm_pkg::KIND_APPEND, -32768, -32768);
      push_item(glnm_pkg::KIND_APPEND, 32767, 32767);
      push_item(glnm_pkg::KIND_MATCH, 32767, 32767);
      push_item(glnm_pkg::KIND_MATCH, -32768, -32767);
      push_item(glnm_pkg::KIND_APPEND, 300, 300);
      push_item(glnm_pkg::KIND_MATCH, 200, 200);
      push_item(glnm_pkg::KIND_CLEAR, -1, -1);
      push_item(glnm_pkg::KIND_MATCH, 0, 0);
      push_item(glnm_pkg::KIND_APPEND, -1, -1);
      push_item(glnm_pkg::KIND_MATCH, -1, -1);
      push_item(glnm_pkg::KIND_MATCH, -32768, -32768);

      sep_plan[0] = '0;
      sep_plan[1] = 15'd1;
      sep_plan[2] = 15'd32767;
      sep_plan[3] = glnm_pkg::MAX_SEP_RESET;
      sep_plan[4] = SEP_W'($urandom_range(2000));
      sep_plan[5] = SEP_W'($urandom_range(32767));
      sep_plan[6] = SEP_W'($urandom_range(32767));
      sep_plan[7] = 15'd32766;

      // Random phases, each under its own separation limit
      for (p = 0; p < 8; p++) begin
         drain();
         write_max_sep(sep_plan[p]);
         idle_pct = (p == 2) ? 0 : 8;
         if (p == 3)
            run_scene(70, 4);
         goal = n_queued + 220;
         while (n_queued < goal) begin
            r = $urandom_range(99);
            if (r < 5)
               run_scene($urandom_range(60, 70), $urandom_range(1, 6));
            else if (r < 10)
               run_scene(0, $urandom_range(1, 3));
            else
               run_scene($urandom_range(1, 12), $urandom_range(1, 6));
         end
      end
      drain();

      $display("covered %0d requests, %0d landmark lookups (%0d matched), %0d appends dropped",
               n_taken, n_lookups, n_hits, n_dropped);
      $display("swept %0d separation limits from 0 to 32767; %0d mismatches",
               n_settings, mismatches);
      if (mismatches == 0)
         $display("gated_nearest_landmark_match verification clean");
      else
         $display("gated_nearest_landmark_match verification failed");
      $finish;
   end

endmodule
